// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file of the slip step block
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define IMSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define IMSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/imss_pkg.sv =====
// shared types, codes and microcode program of the slip step block
// no dependencies
package imss_pkg;

    localparam int PC_W = 6;

    typedef enum logic [2:0] {
        OP_MUL     = 3'd0,
        OP_ADD     = 3'd1,
        OP_DIV     = 3'd2,
        OP_RESTART = 3'd3,
        OP_SLIPCHK = 3'd4,
        OP_END     = 3'd5
    } op_t;

    typedef enum logic [4:0] {
        SEL_ZERO = 5'd0,
        SEL_V    = 5'd1,
        SEL_DT   = 5'd2,
        SEL_VC   = 5'd3,
        SEL_S    = 5'd4,
        SEL_V2   = 5'd5,
        SEL_A    = 5'd6,
        SEL_B    = 5'd7,
        SEL_C    = 5'd8,
        SEL_MT   = 5'd9,
        SEL_EP   = 5'd10,
        SEL_P    = 5'd11,
        SEL_Q    = 5'd12,
        SEL_TC   = 5'd13,
        SEL_TL   = 5'd14,
        SEL_TQ   = 5'd15,
        SEL_R    = 5'd16,
        SEL_X    = 5'd17,
        SEL_IXM  = 5'd18,
        SEL_HI   = 5'd19,
        SEL_VG   = 5'd20
    } sel_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_STALL   = 2'd1,
        EV_RESTART = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        REG_TORQUE_CONST  = 3'd0,
        REG_TORQUE_LINEAR = 3'd1,
        REG_TORQUE_QUAD   = 3'd2,
        REG_ROTOR_RES     = 3'd3,
        REG_REACTANCE     = 3'd4,
        REG_INV_XM        = 3'd5,
        REG_HALF_INV_H    = 3'd6,
        REG_VOLTAGE_GAIN  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        op_t  op;
        sel_t dst;
        sel_t sa;
        sel_t sb;
        sel_t sc;
        logic neg_b;
        logic run_only;
    } instr_t;

    typedef struct packed {
        logic   start;
        logic   exec;
        logic   load_out;
        instr_t ins;
    } imss_cmd_t;

    typedef struct packed {
        logic div_done;
    } imss_stat_t;

    typedef struct packed {
        logic [31:0] torque_const;
        logic [31:0] torque_linear;
        logic [31:0] torque_quadratic;
        logic [31:0] rotor_resistance;
        logic [31:0] reactance_sum;
        logic [31:0] inv_magnetizing_reactance;
        logic [31:0] half_inv_inertia;
        logic [31:0] voltage_gain;
    } imss_cfg_t;

    typedef struct packed {
        logic [31:0] slip;
        logic [31:0] p;
        logic [31:0] q;
        logic        stalled;
        event_t      ev;
        logic        sat;
    } imss_res_t;

    function automatic instr_t mk(op_t op, sel_t dst, sel_t sa, sel_t sb, sel_t sc,
                                  logic neg_b, logic run_only);
        instr_t i;
        i.op       = op;
        i.dst      = dst;
        i.sa       = sa;
        i.sb       = sb;
        i.sc       = sc;
        i.neg_b    = neg_b;
        i.run_only = run_only;
        return i;
    endfunction

    // one tick: torque and power at the current slip, restart test or euler
    // step, then power and reactive power at the new slip
    function automatic instr_t imss_prog(logic [PC_W-1:0] pc);
        unique case (pc)
            6'd0:  return mk(OP_MUL, SEL_VC, SEL_V, SEL_VG, SEL_ZERO, 1'b0, 1'b0);
            6'd1:  return mk(OP_MUL, SEL_A, SEL_S, SEL_S, SEL_ZERO, 1'b0, 1'b0);
            6'd2:  return mk(OP_MUL, SEL_B, SEL_TL, SEL_S, SEL_ZERO, 1'b0, 1'b0);
            6'd3:  return mk(OP_MUL, SEL_C, SEL_TQ, SEL_A, SEL_ZERO, 1'b0, 1'b0);
            6'd4:  return mk(OP_ADD, SEL_MT, SEL_TC, SEL_B, SEL_C, 1'b0, 1'b0);
            6'd5:  return mk(OP_MUL, SEL_V2, SEL_VC, SEL_VC, SEL_ZERO, 1'b0, 1'b0);
            6'd6:  return mk(OP_MUL, SEL_A, SEL_R, SEL_V2, SEL_ZERO, 1'b0, 1'b0);
            6'd7:  return mk(OP_MUL, SEL_A, SEL_A, SEL_S, SEL_ZERO, 1'b0, 1'b0);
            6'd8:  return mk(OP_MUL, SEL_B, SEL_S, SEL_X, SEL_ZERO, 1'b0, 1'b0);
            6'd9:  return mk(OP_MUL, SEL_B, SEL_B, SEL_B, SEL_ZERO, 1'b0, 1'b0);
            6'd10: return mk(OP_MUL, SEL_C, SEL_R, SEL_R, SEL_ZERO, 1'b0, 1'b0);
            6'd11: return mk(OP_ADD, SEL_C, SEL_C, SEL_B, SEL_ZERO, 1'b0, 1'b0);
            6'd12: return mk(OP_DIV, SEL_EP, SEL_A, SEL_C, SEL_ZERO, 1'b0, 1'b0);
            6'd13: return mk(OP_RESTART, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
            6'd14: return mk(OP_ADD, SEL_A, SEL_MT, SEL_EP, SEL_ZERO, 1'b1, 1'b1);
            6'd15: return mk(OP_MUL, SEL_A, SEL_HI, SEL_A, SEL_ZERO, 1'b0, 1'b1);
            6'd16: return mk(OP_MUL, SEL_A, SEL_DT, SEL_A, SEL_ZERO, 1'b0, 1'b1);
            6'd17: return mk(OP_ADD, SEL_S, SEL_S, SEL_A, SEL_ZERO, 1'b0, 1'b1);
            6'd18: return mk(OP_SLIPCHK, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b1);
            6'd19: return mk(OP_MUL, SEL_A, SEL_R, SEL_V2, SEL_ZERO, 1'b0, 1'b0);
            6'd20: return mk(OP_MUL, SEL_A, SEL_A, SEL_S, SEL_ZERO, 1'b0, 1'b0);
            6'd21: return mk(OP_MUL, SEL_B, SEL_S, SEL_X, SEL_ZERO, 1'b0, 1'b0);
            6'd22: return mk(OP_MUL, SEL_B, SEL_B, SEL_B, SEL_ZERO, 1'b0, 1'b0);
            6'd23: return mk(OP_MUL, SEL_C, SEL_R, SEL_R, SEL_ZERO, 1'b0, 1'b0);
            6'd24: return mk(OP_ADD, SEL_C, SEL_C, SEL_B, SEL_ZERO, 1'b0, 1'b0);
            6'd25: return mk(OP_DIV, SEL_P, SEL_A, SEL_C, SEL_ZERO, 1'b0, 1'b0);
            6'd26: return mk(OP_MUL, SEL_A, SEL_S, SEL_S, SEL_ZERO, 1'b0, 1'b0);
            6'd27: return mk(OP_MUL, SEL_A, SEL_X, SEL_A, SEL_ZERO, 1'b0, 1'b0);
            6'd28: return mk(OP_MUL, SEL_B, SEL_R, SEL_R, SEL_ZERO, 1'b0, 1'b0);
            6'd29: return mk(OP_MUL, SEL_C, SEL_A, SEL_X, SEL_ZERO, 1'b0, 1'b0);
            6'd30: return mk(OP_ADD, SEL_B, SEL_B, SEL_C, SEL_ZERO, 1'b0, 1'b0);
            6'd31: return mk(OP_DIV, SEL_C, SEL_A, SEL_B, SEL_ZERO, 1'b0, 1'b0);
            6'd32: return mk(OP_ADD, SEL_C, SEL_IXM, SEL_C, SEL_ZERO, 1'b0, 1'b0);
            6'd33: return mk(OP_MUL, SEL_Q, SEL_V2, SEL_C, SEL_ZERO, 1'b0, 1'b0);
            default: return mk(OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
        endcase
    endfunction

endpackage

// ===== rtl/imss_regs.sv =====
// configuration register bank of the slip step block, apb write and read
// depends on imss_pkg
module imss_regs #(
    parameter int FRAC_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output imss_pkg::imss_cfg_t   cfg
);
    import imss_pkg::*;

    localparam logic [63:0] ONE64    = 64'd1 << FRAC_BITS;
    localparam logic [31:0] RST_TC   = ONE64[31:0];
    localparam logic [30:0] RST_R    = 31'(ONE64 / 64'd100);
    localparam logic [30:0] RST_X    = 31'((64'd3 * ONE64) / 64'd20);
    localparam logic [30:0] RST_IXM  = 31'(ONE64 / 64'd4);
    localparam logic [30:0] RST_ONE  = ONE64[30:0];

    logic [31:0] tc_reg, tl_reg, tq_reg;
    logic [30:0] r_reg, x_reg, ixm_reg, hi_reg, vg_reg;
    logic        wr;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg  <= RST_TC;
            tl_reg  <= '0;
            tq_reg  <= '0;
            r_reg   <= RST_R;
            x_reg   <= RST_X;
            ixm_reg <= RST_IXM;
            hi_reg  <= RST_ONE;
            vg_reg  <= RST_ONE;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_TORQUE_CONST:  tc_reg  <= pwdata;
                REG_TORQUE_LINEAR: tl_reg  <= pwdata;
                REG_TORQUE_QUAD:   tq_reg  <= pwdata;
                REG_ROTOR_RES:     r_reg   <= pwdata[30:0];
                REG_REACTANCE:     x_reg   <= pwdata[30:0];
                REG_INV_XM:        ixm_reg <= pwdata[30:0];
                REG_HALF_INV_H:    hi_reg  <= pwdata[30:0];
                REG_VOLTAGE_GAIN:  vg_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    assign cfg.torque_const              = tc_reg;
    assign cfg.torque_linear             = tl_reg;
    assign cfg.torque_quadratic          = tq_reg;
    assign cfg.rotor_resistance          = {1'b0, r_reg};
    assign cfg.reactance_sum             = {1'b0, x_reg};
    assign cfg.inv_magnetizing_reactance = {1'b0, ixm_reg};
    assign cfg.half_inv_inertia          = {1'b0, hi_reg};
    assign cfg.voltage_gain              = {1'b0, vg_reg};

    always_comb
    begin
        unique case (idx)
            REG_TORQUE_CONST:  prdata = tc_reg;
            REG_TORQUE_LINEAR: prdata = tl_reg;
            REG_TORQUE_QUAD:   prdata = tq_reg;
            REG_ROTOR_RES:     prdata = {1'b0, r_reg};
            REG_REACTANCE:     prdata = {1'b0, x_reg};
            REG_INV_XM:        prdata = {1'b0, ixm_reg};
            REG_HALF_INV_H:    prdata = {1'b0, hi_reg};
            REG_VOLTAGE_GAIN:  prdata = {1'b0, vg_reg};
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== rtl/imss_ctrl.sv =====
// microcode sequencer of the slip step block: handshakes and program counter
// depends on imss_pkg
module imss_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output imss_pkg::imss_cmd_t    cmd,
    input  imss_pkg::imss_stat_t   stat
);
    import imss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_DIVW = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    instr_t          ins;

    assign ins      = imss_prog(pc_reg);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        s_tready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        cmd.ins      = ins;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    pc_next    = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (ins.op == OP_DIV)
                    state_next = ST_DIVW;
                else if (ins.op == OP_END)
                    state_next = ST_FIN;
                else
                    pc_next = pc_reg + 1'b1;
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_FIN:
            begin
                // waits only while the previous result is still unclaimed
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/imss_div.sv =====
// fixed point divider, (n << FRAC_BITS) / d toward zero with saturation
// radix 4 restoring long division on magnitudes; no package dependency
module imss_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot,
    output logic        sat
);
    localparam int DW    = 32 + FRAC_BITS;
    localparam int DWE   = DW + (DW % 2);
    localparam int ITER  = DWE / 2;
    localparam int CNT_W = $clog2(ITER + 1);
    localparam logic [DWE-1:0] LIM_POS = DWE'(64'h7FFF_FFFF);
    localparam logic [DWE-1:0] LIM_NEG = DWE'(64'h8000_0000);
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg, dmag_reg, rem_step;
    logic [DWE-1:0]   dvd_reg, quo_reg, dvd_step, quo_step;
    logic             neg_reg, zden_reg, nzero_reg, nneg_reg;
    logic [31:0]      nmag, dmag;

    assign nmag = num[31] ? (~num + 32'd1) : num;
    assign dmag = den[31] ? (~den + 32'd1) : den;

    // two quotient bits a cycle
    always_comb
    begin
        logic [32:0] t;
        rem_step = rem_reg;
        dvd_step = dvd_reg;
        quo_step = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            t        = {rem_step, dvd_step[DWE-1]};
            dvd_step = {dvd_step[DWE-2:0], 1'b0};
            if (t >= {1'b0, dmag_reg})
            begin
                t        = t - {1'b0, dmag_reg};
                quo_step = {quo_step[DWE-2:0], 1'b1};
            end
            else
                quo_step = {quo_step[DWE-2:0], 1'b0};
            rem_step = t[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ITER);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            dmag_reg  <= dmag;
            dvd_reg   <= DWE'(nmag) << FRAC_BITS;
            quo_reg   <= '0;
            neg_reg   <= num[31] ^ den[31];
            zden_reg  <= (den == 32'd0);
            nzero_reg <= (num == 32'd0);
            nneg_reg  <= num[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dvd_reg <= dvd_step;
            quo_reg <= quo_step;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        sat  = 1'b0;
        quot = quo_reg[31:0];
        if (zden_reg)
        begin
            sat  = !nzero_reg;
            quot = nzero_reg ? 32'd0 : (nneg_reg ? SAT_MIN : SAT_MAX);
        end
        else if (neg_reg)
        begin
            if (quo_reg > LIM_NEG)
            begin
                sat  = 1'b1;
                quot = SAT_MIN;
            end
            else
                quot = ~quo_reg[31:0] + 32'd1;
        end
        else if (quo_reg > LIM_POS)
        begin
            sat  = 1'b1;
            quot = SAT_MAX;
        end
    end

endmodule

// ===== rtl/imss_dp.sv =====
// datapath of the slip step block: operand registers, multiplier, adder,
// divider, slip and stall state; depends on imss_pkg and imss_div
module imss_dp #(
    parameter int FRAC_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  imss_pkg::imss_cmd_t    cmd,
    output imss_pkg::imss_stat_t   stat,
    input  imss_pkg::imss_cfg_t    cfg,
    input  logic [30:0]            line_voltage,
    input  logic [30:0]            time_step,
    output imss_pkg::imss_res_t    res
);
    import imss_pkg::*;

    localparam logic [63:0] ONE64    = 64'd1 << FRAC_BITS;
    localparam logic [31:0] ONE      = ONE64[31:0];
    localparam logic [31:0] ONE_M1   = ONE - 32'd1;
    localparam logic [30:0] HALF     = ONE64[31:1];
    localparam logic [31:0] SLIP_RST = 32'((64'd3 * ONE64) / 64'd100);
    localparam logic [31:0] SAT_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN  = 32'h8000_0000;

    logic [31:0] vc_reg, s_reg, v2_reg, a_reg, b_reg, c_reg;
    logic [31:0] mt_reg, ep_reg, p_reg, q_reg, s_next;
    logic [30:0] v_reg, dt_reg;
    logic        run_reg, stall_reg, stall_next, sat_reg, sat_next;
    event_t      ev_reg, ev_next;
    imss_res_t   res_reg;

    instr_t      ins;
    sel_t        sels [3];
    logic [31:0] ops  [3];
    logic        exec_ok;

    logic signed [63:0] prod;
    logic [63:0]        prod_sh;
    logic               mul_sat;
    logic [31:0]        mul_val;
    logic [33:0]        sum, bx;
    logic               add_sat;
    logic [31:0]        add_val;

    logic        div_start, div_done, div_sat;
    logic [31:0] div_q;
    logic        wr_en;
    logic [31:0] wr_val;

    assign ins     = cmd.ins;
    assign exec_ok = cmd.exec && (!ins.run_only || run_reg);

    always_comb
    begin
        sels[0] = ins.sa;
        sels[1] = ins.sb;
        sels[2] = ins.sc;
        for (int k = 0; k < 3; k++)
        begin
            unique case (sels[k])
                SEL_ZERO: ops[k] = '0;
                SEL_V:    ops[k] = {1'b0, v_reg};
                SEL_DT:   ops[k] = {1'b0, dt_reg};
                SEL_VC:   ops[k] = vc_reg;
                SEL_S:    ops[k] = s_reg;
                SEL_V2:   ops[k] = v2_reg;
                SEL_A:    ops[k] = a_reg;
                SEL_B:    ops[k] = b_reg;
                SEL_C:    ops[k] = c_reg;
                SEL_MT:   ops[k] = mt_reg;
                SEL_EP:   ops[k] = ep_reg;
                SEL_P:    ops[k] = p_reg;
                SEL_Q:    ops[k] = q_reg;
                SEL_TC:   ops[k] = cfg.torque_const;
                SEL_TL:   ops[k] = cfg.torque_linear;
                SEL_TQ:   ops[k] = cfg.torque_quadratic;
                SEL_R:    ops[k] = cfg.rotor_resistance;
                SEL_X:    ops[k] = cfg.reactance_sum;
                SEL_IXM:  ops[k] = cfg.inv_magnetizing_reactance;
                SEL_HI:   ops[k] = cfg.half_inv_inertia;
                SEL_VG:   ops[k] = cfg.voltage_gain;
                default:  ops[k] = '0;
            endcase
        end
    end

    // product floors toward minus infinity, then saturates
    always_comb
    begin
        prod    = $signed(ops[0]) * $signed(ops[1]);
        prod_sh = 64'(prod >>> FRAC_BITS);
        mul_sat = !((&prod_sh[63:31]) || !(|prod_sh[63:31]));
        mul_val = mul_sat ? (prod_sh[63] ? SAT_MIN : SAT_MAX) : prod_sh[31:0];
    end

    // three-term exact sum, saturated once
    always_comb
    begin
        bx      = ins.neg_b ? (~{{2{ops[1][31]}}, ops[1]} + 34'd1)
                            : {{2{ops[1][31]}}, ops[1]};
        sum     = {{2{ops[0][31]}}, ops[0]} + bx + {{2{ops[2][31]}}, ops[2]};
        add_sat = !((&sum[33:31]) || !(|sum[33:31]));
        add_val = add_sat ? (sum[33] ? SAT_MIN : SAT_MAX) : sum[31:0];
    end

    imss_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ops[0]),
        .den   (ops[1]),
        .done  (div_done),
        .quot  (div_q),
        .sat   (div_sat)
    );

    assign stat.div_done = div_done;

    always_comb
    begin
        wr_en      = 1'b0;
        wr_val     = mul_val;
        div_start  = 1'b0;
        s_next     = s_reg;
        stall_next = stall_reg;
        ev_next    = ev_reg;
        sat_next   = sat_reg;
        if (cmd.start)
        begin
            sat_next = 1'b0;
            ev_next  = EV_NONE;
        end
        if (exec_ok)
        begin
            unique case (ins.op)
                OP_MUL:
                begin
                    wr_en    = 1'b1;
                    wr_val   = mul_val;
                    sat_next = sat_reg | mul_sat;
                end
                OP_ADD:
                begin
                    wr_en    = 1'b1;
                    wr_val   = add_val;
                    sat_next = sat_reg | add_sat;
                end
                OP_DIV: div_start = 1'b1;
                OP_RESTART:
                begin
                    // only a tick that began stalled may restart
                    if (!run_reg && ($signed(ep_reg) > $signed(mt_reg)) && (v_reg > HALF))
                    begin
                        s_next     = ONE_M1;
                        stall_next = 1'b0;
                        ev_next    = EV_RESTART;
                    end
                end
                OP_SLIPCHK:
                begin
                    if ($signed(s_reg) >= $signed(ONE))
                    begin
                        s_next     = ONE;
                        stall_next = 1'b1;
                        ev_next    = EV_STALL;
                    end
                end
                OP_END: ;
                default: ;
            endcase
        end
        if (div_done)
        begin
            wr_en    = 1'b1;
            wr_val   = div_q;
            sat_next = sat_reg | div_sat;
        end
        if (wr_en && (ins.dst == SEL_S))
            s_next = wr_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg     <= SLIP_RST;
            stall_reg <= 1'b0;
            run_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            ev_reg    <= EV_NONE;
        end
        else
        begin
            s_reg     <= s_next;
            stall_reg <= stall_next;
            sat_reg   <= sat_next;
            ev_reg    <= ev_next;
            if (cmd.start)
                run_reg <= !stall_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            v_reg  <= line_voltage;
            dt_reg <= time_step;
        end
        if (wr_en)
        begin
            unique case (ins.dst)
                SEL_VC:  vc_reg <= wr_val;
                SEL_V2:  v2_reg <= wr_val;
                SEL_A:   a_reg  <= wr_val;
                SEL_B:   b_reg  <= wr_val;
                SEL_C:   c_reg  <= wr_val;
                SEL_MT:  mt_reg <= wr_val;
                SEL_EP:  ep_reg <= wr_val;
                SEL_P:   p_reg  <= wr_val;
                SEL_Q:   q_reg  <= wr_val;
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            res_reg.slip    <= s_reg;
            res_reg.p       <= p_reg;
            res_reg.q       <= q_reg;
            res_reg.stalled <= stall_reg;
            res_reg.ev      <= ev_reg;
            res_reg.sat     <= sat_reg;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/induction_motor_slip_step_top.sv =====
// Induction motor slip step: one input beat (line voltage, time step) gives one
// result beat (slip, P, Q, stall status, stall event, saturation flag). A tick
// runs a 35-step microcode program on one 32x32 multiplier, one three-input
// adder and one radix-4 divider. One tick is in flight at a time; the next input
// beat is taken as soon as the result sits in the output register, even if it
// has not been taken yet. Registers must be written through the apb port only
// while idle, by the user; the block itself does not enforce it.
// depends on imss_pkg, imss_regs, imss_ctrl, imss_dp
module induction_motor_slip_step_top #(
    parameter int FRAC_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // line_voltage[30:0], time_step[61:31]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // slip_out, real_power, reactive_power,
                                    // is_stalled, stall_event[1:0], saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import imss_pkg::*;

    imss_cfg_t  cfg;
    imss_cmd_t  cmd;
    imss_stat_t stat;
    imss_res_t  res;

    imss_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    imss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    imss_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg          (cfg),
        .line_voltage (s_tdata[30:0]),
        .time_step    (s_tdata[61:31]),
        .res          (res)
    );

    assign m_tdata = {4'b0000, res.sat, res.ev, res.stalled, res.q, res.p, res.slip};

endmodule

// ===== rtl/imss_checker.sv =====
// port-level checks of the slip step block, bound to the top level
// depends on imss_pkg and assert_macros.svh
`include "assert_macros.svh"

module imss_checker #(
    parameter int FRAC_BITS = 24
) (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);
    import imss_pkg::*;

    localparam logic [63:0] ONE64  = 64'd1 << FRAC_BITS;
    localparam logic [31:0] ONE    = ONE64[31:0];
    localparam logic [31:0] ONE_M1 = ONE - 32'd1;

    `IMSS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
    `IMSS_ASSERT(a_one_tick, s_tvalid && s_tready |=> !s_tready, "input beat taken while a tick runs")
    `IMSS_ASSERT(a_stall_pin, m_tvalid && m_tdata[96] |-> (m_tdata[31:0] == ONE), "stalled result with slip other than one")
    `IMSS_ASSERT(a_restart, m_tvalid && (m_tdata[98:97] == EV_RESTART) |-> !m_tdata[96] && (m_tdata[31:0] == ONE_M1), "restart result inconsistent")
    // the asynchronous reset clears the output register, so valid is checked low after every sampled reset
    `IMSS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind induction_motor_slip_step_top imss_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_imss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/testbench.sv =====
// self-checking bench for the induction motor slip step block: a predictor class
// computes every tick result in fixed point and checks the result stream
// depends on imss_pkg and induction_motor_slip_step_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import imss_pkg::*;

    localparam int     FB     = 24;
    localparam longint ONE    = longint'(1) << FB;
    localparam longint MAX_FX = 64'sd2147483647;
    localparam longint MIN_FX = -64'sd2147483648;
    localparam int     N_PHASES = 9;
    localparam int     RAND_PER_PHASE = 190;

    typedef struct {
        logic [31:0] slip;
        logic [31:0] p;
        logic [31:0] q;
        logic        stalled;
        event_t      ev;
        logic        sat;
    } tick_res_t;

    class slip_scoreboard;
        longint tc, tl, tq, res_r, reac_x, inv_xm, half_h, vgain;
        longint slip;
        bit     stalled;
        bit     sat_hit;
        int     errors;
        int     ticks, stalls, restarts, sat_ticks;
        tick_res_t pending[$];

        function new();
            tc = ONE; tl = 0; tq = 0;
            res_r = ONE / 100; reac_x = (3 * ONE) / 20; inv_xm = ONE / 4;
            half_h = ONE; vgain = ONE;
            slip = (3 * ONE) / 100;
            stalled = 0;
            errors = 0; ticks = 0; stalls = 0; restarts = 0; sat_ticks = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_TORQUE_CONST:  tc = longint'(signed'(val));
                REG_TORQUE_LINEAR: tl = longint'(signed'(val));
                REG_TORQUE_QUAD:   tq = longint'(signed'(val));
                REG_ROTOR_RES:     res_r = longint'(val[30:0]);
                REG_REACTANCE:     reac_x = longint'(val[30:0]);
                REG_INV_XM:        inv_xm = longint'(val[30:0]);
                REG_HALF_INV_H:    half_h = longint'(val[30:0]);
                REG_VOLTAGE_GAIN:  vgain = longint'(val[30:0]);
                default: ;
            endcase
        endfunction

        function longint clamp(longint x);
            if (x > MAX_FX)
            begin
                sat_hit = 1;
                return MAX_FX;
            end
            if (x < MIN_FX)
            begin
                sat_hit = 1;
                return MIN_FX;
            end
            return x;
        endfunction

        // arithmetic shift gives the floor rounding
        function longint fx_mul(longint a, longint b);
            return clamp((a * b) >>> FB);
        endfunction

        function longint fx_div(longint n, longint d);
            if (d == 0)
            begin
                if (n == 0)
                    return 0;
                sat_hit = 1;
                return (n > 0) ? MAX_FX : MIN_FX;
            end
            return clamp((n * ONE) / d);
        endfunction

        function longint torque_at(longint s);
            longint s2;
            s2 = fx_mul(s, s);
            return clamp(tc + fx_mul(tl, s) + fx_mul(tq, s2));
        endfunction

        function longint power_at(longint v, longint s);
            longint v2, num, xs, den;
            v2 = fx_mul(v, v);
            num = fx_mul(fx_mul(res_r, v2), s);
            xs = fx_mul(s, reac_x);
            den = clamp(fx_mul(res_r, res_r) + fx_mul(xs, xs));
            return fx_div(num, den);
        endfunction

        function longint reactive_at(longint v, longint s);
            longint v2, xs2, den, frac;
            v2 = fx_mul(v, v);
            xs2 = fx_mul(reac_x, fx_mul(s, s));
            den = clamp(fx_mul(res_r, res_r) + fx_mul(xs2, reac_x));
            frac = fx_div(xs2, den);
            return fx_mul(v2, clamp(inv_xm + frac));
        endfunction

        function void note_input(logic [30:0] volt, logic [30:0] step);
            longint v, dt, vc, p1, m1, diff, deriv;
            tick_res_t r;
            v = longint'(volt);
            dt = longint'(step);
            sat_hit = 0;
            r.ev = EV_NONE;
            vc = fx_mul(v, vgain);
            if (stalled)
            begin
                p1 = power_at(vc, ONE);
                m1 = torque_at(ONE);
                if (p1 - m1 > 0 && v > ONE / 2)
                begin
                    stalled = 0;
                    slip = ONE - 1;
                    r.ev = EV_RESTART;
                    restarts++;
                end
            end
            else
            begin
                diff = clamp(torque_at(slip) - power_at(vc, slip));
                deriv = fx_mul(half_h, diff);
                slip = clamp(slip + fx_mul(dt, deriv));
                if (slip >= ONE)
                begin
                    stalled = 1;
                    slip = ONE;
                    r.ev = EV_STALL;
                    stalls++;
                end
            end
            r.p = 32'(power_at(vc, slip));
            r.q = 32'(reactive_at(vc, slip));
            r.slip = 32'(slip);
            r.stalled = stalled;
            r.sat = sat_hit;
            if (sat_hit)
                sat_ticks++;
            ticks++;
            pending.push_back(r);
        endfunction

        function void check_result(logic [103:0] d);
            tick_res_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with no tick pending: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.slip)
            begin
                $error("slip_out expected %h actual %h", e.slip, d[31:0]);
                errors++;
            end
            if (d[63:32] !== e.p)
            begin
                $error("real_power expected %h actual %h", e.p, d[63:32]);
                errors++;
            end
            if (d[95:64] !== e.q)
            begin
                $error("reactive_power expected %h actual %h", e.q, d[95:64]);
                errors++;
            end
            if (d[96] !== e.stalled)
            begin
                $error("is_stalled expected %0d actual %0d", e.stalled, d[96]);
                errors++;
            end
            if (d[98:97] !== e.ev)
            begin
                $error("stall_event expected %0d actual %0d", e.ev, d[98:97]);
                errors++;
            end
            if (d[99] !== e.sat)
            begin
                $error("saturated expected %0d actual %0d", e.sat, d[99]);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;  // line_voltage[30:0], time_step[61:31]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;       // slip_out, real_power, reactive_power,
                                 // is_stalled, stall_event[1:0], saturated
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    slip_scoreboard sb = new();
    bit             send_gaps = 0;
    bit             recv_stalls = 0;
    int             idle_pct = 76;
    int             hold_left = 0;
    logic [31:0]    cfg [8];

    induction_motor_slip_step_top #(.FRAC_BITS(FB)) dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: check accepted beats, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (recv_stalls)
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        else
            m_tready <= 1'b1;
    end

    task automatic apb_write(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(int'(idx) * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_cfg();
        for (int i = 0; i < 8; i++)
            apb_write(reg_idx_t'(i), cfg[i]);
    endtask

    task automatic send_tick(logic [30:0] volt, logic [30:0] step);
        if (send_gaps)
            while ($urandom_range(0, 99) < idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, step, volt};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(volt, step);
    endtask

    // sender stops, every result drains, block settles before the next write
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic random_cfg(int ph);
        cfg[REG_TORQUE_CONST]  = 32'(longint'($urandom_range(0, 2 * ONE)) - ONE / 4);
        cfg[REG_TORQUE_LINEAR] = 32'(longint'($urandom_range(0, ONE)) - ONE / 2);
        cfg[REG_TORQUE_QUAD]   = 32'(longint'($urandom_range(0, 2 * ONE)) - ONE / 2);
        cfg[REG_ROTOR_RES]     = $urandom_range(ONE / 256, ONE / 4);
        cfg[REG_REACTANCE]     = $urandom_range(0, ONE / 2);
        cfg[REG_INV_XM]        = $urandom_range(0, ONE);
        cfg[REG_HALF_INV_H]    = $urandom_range(ONE / 8, 2 * ONE);
        cfg[REG_VOLTAGE_GAIN]  = $urandom_range(ONE / 2, 3 * ONE / 2);
        // now and then one register takes any value, upper bit included
        if (ph % 2 == 1)
            cfg[$urandom_range(0, 7)] = $urandom();
    endtask

    task automatic random_tick();
        logic [30:0] v, dt;
        if ($urandom_range(0, 99) < 80)
        begin
            v = 31'($urandom_range(0, 3 * ONE));
            dt = 31'($urandom_range(0, ONE / 8));
        end
        else
        begin
            v = 31'($urandom());
            dt = 31'($urandom());
        end
        send_tick(v, dt);
    endtask

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // defaults written back explicitly
        cfg[REG_TORQUE_CONST]  = 32'(ONE);
        cfg[REG_TORQUE_LINEAR] = 32'd0;
        cfg[REG_TORQUE_QUAD]   = 32'd0;
        cfg[REG_ROTOR_RES]     = 32'(ONE / 100);
        cfg[REG_REACTANCE]     = 32'((3 * ONE) / 20);
        cfg[REG_INV_XM]        = 32'(ONE / 4);
        cfg[REG_HALF_INV_H]    = 32'(ONE);
        cfg[REG_VOLTAGE_GAIN]  = 32'(ONE);
        load_cfg();

        // directed: nominal, zero step, stall and restart paths
        send_tick(31'(ONE), 31'(ONE / 100));
        send_tick(31'(ONE), 31'd0);
        send_tick(31'd0, 31'd0);
        send_tick(31'd0, 31'h7fffffff);          // huge step, slip runs past 1 and stalls
        send_tick(31'(ONE / 2), 31'd0);          // stalled, voltage exactly half: no restart
        send_tick(31'(ONE / 4), 31'(ONE));       // stalled, too weak to restart
        send_tick(31'(3 * ONE), 31'd0);          // restart
        send_tick(31'h7fffffff, 31'(ONE / 100)); // full scale voltage saturates
        send_tick(31'h7fffffff, 31'h7fffffff);
        send_tick(31'(ONE), 31'h7fffffff);
        send_tick(31'd0, 31'h7fffffff);
        send_tick(31'h7fffffff, 31'd0);
        drain();

        // zero resistance and reactance: zero denominators
        cfg[REG_ROTOR_RES] = 32'd0;
        cfg[REG_REACTANCE] = 32'd0;
        load_cfg();
        send_tick(31'(ONE), 31'(ONE / 100));
        send_tick(31'd0, 31'(ONE / 100));
        send_tick(31'(2 * ONE), 31'h7fffffff);
        send_tick(31'(2 * ONE), 31'd0);
        drain();

        // register extremes, high then low
        foreach (cfg[i]) cfg[i] = 32'h7fffffff;
        cfg[REG_TORQUE_LINEAR] = 32'h8000_0000;
        load_cfg();
        send_tick(31'(ONE), 31'(ONE / 16));
        send_tick(31'h7fffffff, 31'h7fffffff);
        send_tick(31'(ONE), 31'd1);
        drain();
        foreach (cfg[i]) cfg[i] = 32'd0;
        cfg[REG_TORQUE_CONST] = 32'h8000_0000;
        cfg[REG_TORQUE_QUAD]  = 32'h8000_0000;
        cfg[REG_ROTOR_RES]    = 32'd1;
        cfg[REG_HALF_INV_H]   = 32'hffff_ffff;
        load_cfg();
        send_tick(31'(ONE), 31'(ONE / 16));
        send_tick(31'h7fffffff, 31'h7fffffff);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            random_cfg(ph);
            load_cfg();
            send_gaps = (ph % 4 == 1) || (ph % 4 == 3);
            recv_stalls = (ph % 4 == 2) || (ph % 4 == 3);
            // both sides idle lightly together, heavily when alone
            idle_pct = (ph % 4 == 3) ? 7 : 76;
            if (ph == 2)
                hold_left = 600;
            for (int n = 0; n < RAND_PER_PHASE; n++)
                random_tick();
            drain();
        end

        $display("checked %0d ticks over %0d register settings", sb.ticks, N_PHASES + 4);
        $display("saw %0d stalls, %0d restarts, %0d ticks with saturation",
                 sb.stalls, sb.restarts, sb.sat_ticks);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
